// File: design/column_ray_marcher_macros.svh
// Assertion macros shared by the column ray marcher modules.
// Each macro expects clk and arst_n in the scope of the module that uses it.
`ifndef COLUMN_RAY_MARCHER_MACROS_SVH
`define COLUMN_RAY_MARCHER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CRM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("column_ray_marcher: assertion failed");

// Next-cycle implication, disabled while in reset
`define CRM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("column_ray_marcher: assertion failed");

`endif

// File: design/crm_pkg.sv
// Shared types and constants of the column ray marcher.
// Used by crm_ctrl, crm_dpath and column_ray_marcher; depends on nothing.
package crm_pkg;

	localparam int unsigned TURN    = 3840;
	localparam int unsigned QUARTER = 960;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned SCALE_W    = 16;
	localparam int unsigned SCALE_RESET = 480;
	localparam int unsigned ROM_IDX_W  = 10;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_CAST = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIN,
		ST_COS,
		ST_SETX,
		ST_MARCH,
		ST_DIVI,
		ST_DIV,
		ST_WB
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic rom_rd;
		logic rom_cos;
		logic dy_ld;
		logic dx_ld;
		logic march;
		logic div_ld;
		logic div_step;
		logic out_ld;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic wall;
		logic last_step;
		logic div_done;
		logic out_free;
	} sts_t;

	// Sine over a quarter turn in Q1.frac, Taylor series through x^9 in Q30
	function automatic longint unsigned quarter_sine(input int unsigned r,
		input int unsigned frac);
		longint unsigned x, x2, x3, x5, x7, x9;
		longint s, v, one;
		x  = (longint'(r) * PI_Q30 + 64'd960) / 64'd1920;
		x2 = (x * x) >> 30;
		x3 = (x2 * x) >> 30;
		x5 = (x3 * x2) >> 30;
		x7 = (x5 * x2) >> 30;
		x9 = (x7 * x2) >> 30;
		s = longint'(x) + longint'(x5 / 64'd120) + longint'(x9 / 64'd362880)
			- longint'(x3 / 64'd6) - longint'(x7 / 64'd5040);
		one = 64'sd1 <<< frac;
		if (s < 0) begin
			s = 0;
		end
		v = (s + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
		if (v > one) begin
			v = one;
		end
		return longint'(v);
	endfunction

endpackage

// File: design/crm_ctrl.sv
// Controller of the column ray marcher: sequences direction lookup, march,
// line height divide and result write-back. Depends on crm_pkg and the macros.
`include "column_ray_marcher_macros.svh"

module crm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	input  logic            func,
	input  crm_pkg::sts_t   sts,
	output logic            s_ready,
	output crm_pkg::cmd_t   cmd
);

	crm_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			crm_pkg::ST_IDLE: begin
				if (s_valid && func == crm_pkg::FUNC_CAST) state_d = crm_pkg::ST_SIN;
			end
			crm_pkg::ST_SIN:  state_d = crm_pkg::ST_COS;
			crm_pkg::ST_COS:  state_d = crm_pkg::ST_SETX;
			crm_pkg::ST_SETX: state_d = crm_pkg::ST_MARCH;
			crm_pkg::ST_MARCH: begin
				if (sts.wall) state_d = crm_pkg::ST_DIVI;
				else if (sts.last_step) state_d = crm_pkg::ST_WB;
			end
			crm_pkg::ST_DIVI: state_d = crm_pkg::ST_DIV;
			crm_pkg::ST_DIV: begin
				if (sts.div_done) state_d = crm_pkg::ST_WB;
			end
			crm_pkg::ST_WB: begin
				if (sts.out_free) state_d = crm_pkg::ST_IDLE;
			end
			default: state_d = crm_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		s_ready = 1'b0;
		case (state_q)
			crm_pkg::ST_IDLE: begin
				s_ready = 1'b1;
				cmd.accept = s_valid;
			end
			crm_pkg::ST_SIN: cmd.rom_rd = 1'b1;
			crm_pkg::ST_COS: begin
				cmd.rom_rd  = 1'b1;
				cmd.rom_cos = 1'b1;
				cmd.dy_ld   = 1'b1;
			end
			crm_pkg::ST_SETX:  cmd.dx_ld = 1'b1;
			crm_pkg::ST_MARCH: cmd.march = 1'b1;
			crm_pkg::ST_DIVI:  cmd.div_ld = 1'b1;
			crm_pkg::ST_DIV:   cmd.div_step = 1'b1;
			crm_pkg::ST_WB:    cmd.out_ld = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`CRM_ASSERT_NXT(a_wall_to_div, (state_q == crm_pkg::ST_MARCH) && sts.wall, state_q == crm_pkg::ST_DIVI)
	`CRM_ASSERT_NXT(a_wb_leaves, cmd.out_ld, state_q == crm_pkg::ST_IDLE)

endmodule

// File: design/crm_dpath.sv
// Datapath of the column ray marcher: wall map, direction table, march
// registers, serial divider and result register. Depends on crm_pkg and the macros.
`include "column_ray_marcher_macros.svh"

module crm_dpath #(
	parameter int MAP_CELLS   = 10,
	parameter int TILE_SHIFT  = 6,
	parameter int COLUMNS     = 640,
	parameter int SCREEN_ROWS = 480,
	parameter int MAX_STEPS   = 1024,
	parameter int FRAC_BITS   = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  crm_pkg::cmd_t                       cmd,
	output crm_pkg::sts_t                       sts,
	input  logic                                func,
	input  logic [crm_pkg::IN_DATA_W-1:0]       in_data,
	input  logic                                cfg_we,
	input  logic [crm_pkg::SCALE_W-1:0]         cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [crm_pkg::OUT_DATA_W-1:0]      out_data,
	output logic                                out_hit
);

	localparam int MW   = $clog2(MAP_CELLS);
	localparam int MAPW = MW + TILE_SHIFT + FRAC_BITS;
	localparam int PW   = ((MAPW > 24) ? MAPW : 24) + 2;
	localparam int TW   = PW - TILE_SHIFT - FRAC_BITS;
	localparam int DW   = FRAC_BITS + 2;
	localparam int SW   = $clog2(MAX_STEPS + 1);
	localparam int QW   = crm_pkg::SCALE_W;
	localparam int ABASE = 2 * 3840 - COLUMNS / 2;
	localparam int TURN_I = 3840;

	typedef struct packed {
		logic [crm_pkg::ROM_IDX_W-1:0] idx;
		logic                          neg;
	} quad_t;

	// Input fields
	logic [3:0]  map_row;
	logic [9:0]  row_walls, column;
	logic [23:0] pos_x, pos_y;
	logic [11:0] view_angle;
	assign map_row    = in_data[3:0];
	assign row_walls  = in_data[13:4];
	assign column     = in_data[23:14];
	assign pos_x      = in_data[47:24];
	assign pos_y      = in_data[71:48];
	assign view_angle = in_data[83:72];

	// Fold an angle below one turn onto the quarter table
	function automatic quad_t fold(input logic [11:0] a);
		quad_t o;
		logic [11:0] r;
		logic        odd;
		if (a >= 12'd2880) begin
			r = a - 12'd2880; odd = 1'b1; o.neg = 1'b1;
		end else if (a >= 12'd1920) begin
			r = a - 12'd1920; odd = 1'b0; o.neg = 1'b1;
		end else if (a >= 12'd960) begin
			r = a - 12'd960; odd = 1'b1; o.neg = 1'b0;
		end else begin
			r = a; odd = 1'b0; o.neg = 1'b0;
		end
		o.idx = odd ? 10'(12'd960 - r) : r[9:0];
		return o;
	endfunction

	// Constant quarter-sine table
	logic [FRAC_BITS:0] sin_tab [0:crm_pkg::QUARTER];
	for (genvar g = 0; g <= crm_pkg::QUARTER; g++) begin : g_rom
		assign sin_tab[g] = (FRAC_BITS+1)'(crm_pkg::quarter_sine(g, FRAC_BITS));
	end

	// Height scale register
	logic [QW-1:0] scale_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= QW'(crm_pkg::SCALE_RESET);
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	// Wall map rows, border walled at reset
	logic [MAP_CELLS-1:0] map_q [MAP_CELLS];
	logic [MAP_CELLS+9:0] wext;
	logic [MW+3:0]        rext;
	logic                 row_ok;
	assign wext   = {{MAP_CELLS{1'b0}}, row_walls};
	assign rext   = {{MW{1'b0}}, map_row};
	assign row_ok = 32'(map_row) < MAP_CELLS;

	for (genvar r = 0; r < MAP_CELLS; r++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				if (r == 0 || r == MAP_CELLS - 1) begin
					map_q[r] <= '1;
				end else begin
					map_q[r] <= MAP_CELLS'(1) | (MAP_CELLS'(1) << (MAP_CELLS - 1));
				end
			end else if (cmd.accept && func == crm_pkg::FUNC_LOAD && row_ok
				&& rext[MW-1:0] == MW'(r)) begin
				map_q[r] <= wext[MAP_CELLS-1:0];
			end
		end
	end

	// Ray angle reduced below one turn
	logic [14:0] asum, a1, a2, a3;
	logic [11:0] t_q, tc;
	logic [12:0] tc_raw;
	assign asum = 15'(view_angle) + 15'(ABASE) + 15'(column);
	assign a1 = (asum >= 15'(TURN_I)) ? asum - 15'(TURN_I) : asum;
	assign a2 = (a1 >= 15'(TURN_I)) ? a1 - 15'(TURN_I) : a1;
	assign a3 = (a2 >= 15'(TURN_I)) ? a2 - 15'(TURN_I) : a2;
	assign tc_raw = 13'(t_q) + 13'(crm_pkg::QUARTER);
	assign tc = (tc_raw >= 13'(TURN_I)) ? 12'(tc_raw - 13'(TURN_I)) : tc_raw[11:0];

	// Table read, registered
	quad_t              fq;
	logic [FRAC_BITS:0] rom_q;
	logic               rneg_q;
	assign fq = fold(cmd.rom_cos ? tc : t_q);
	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			rom_q  <= sin_tab[fq.idx];
			rneg_q <= fq.neg;
		end
	end

	logic signed [DW-1:0] dir, dx_q, dy_q;
	assign dir = rneg_q ? -signed'({1'b0, rom_q}) : signed'({1'b0, rom_q});

	// March registers
	logic signed [PW-1:0] px_q, py_q, px_n, py_n;
	logic [SW-1:0]        steps_q;
	logic [9:0]           col_q;
	logic                 hit_q;
	assign px_n = px_q + PW'(dx_q);
	assign py_n = py_q + PW'(dy_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q  <= signed'(PW'(pos_x));
			py_q  <= signed'(PW'(pos_y));
			col_q <= column;
			t_q   <= a3[11:0];
		end
		if (cmd.dy_ld) dy_q <= dir;
		if (cmd.dx_ld) dx_q <= dir;
		if (cmd.march) begin
			px_q <= px_n;
			py_q <= py_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			hit_q   <= 1'b0;
		end else if (cmd.accept) begin
			steps_q <= '0;
			hit_q   <= 1'b0;
		end else if (cmd.march) begin
			steps_q <= steps_q + SW'(1);
			hit_q   <= sts.wall;
		end
	end

	// Tile test of the next position
	logic [TW-1:0] tx, ty;
	logic          oob;
	logic [MAP_CELLS-1:0] wrow;
	assign tx  = px_n[PW-1 -: TW];
	assign ty  = py_n[PW-1 -: TW];
	assign oob = px_n[PW-1] || py_n[PW-1] || (tx >= TW'(MAP_CELLS)) || (ty >= TW'(MAP_CELLS));
	assign wrow = map_q[ty[MW-1:0]];
	assign sts.wall = oob || wrow[tx[MW-1:0]];
	assign sts.last_step = steps_q == SW'(MAX_STEPS - 1);

	// Restoring divider, one quotient bit a cycle
	logic [QW-1:0] num_q;
	logic [SW-1:0] rem_q;
	logic [SW:0]   rcand;
	logic [3:0]    dcnt_q;
	logic          ge;
	assign rcand = {rem_q, num_q[QW-1]};
	assign ge    = rcand >= {1'b0, steps_q};
	always_ff @(posedge clk) begin
		if (cmd.div_ld) begin
			num_q  <= scale_q;
			rem_q  <= '0;
			dcnt_q <= 4'(QW - 1);
		end else if (cmd.div_step) begin
			rem_q  <= ge ? SW'(rcand - {1'b0, steps_q}) : SW'(rcand);
			num_q  <= {num_q[QW-2:0], ge};
			dcnt_q <= dcnt_q - 4'd1;
		end
	end
	assign sts.div_done = dcnt_q == 4'd0;

	// Line span
	logic [16:0]   q17, hh, top17, bot17;
	logic [SW+10:0] sext;
	assign q17   = hit_q ? 17'(num_q) : 17'd0;
	assign hh    = (q17 > 17'(SCREEN_ROWS)) ? 17'(SCREEN_ROWS) : q17;
	assign top17 = (17'(SCREEN_ROWS) - hh) >> 1;
	assign bot17 = (17'(SCREEN_ROWS) + hh) >> 1;
	assign sext  = {11'd0, steps_q};

	// Result register
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_data <= {2'b00, bot17[8:0], top17[7:0], sext[10:0], col_q};
			out_hit  <= hit_q;
		end
	end
	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

	`CRM_ASSERT_IMP(a_div_nonzero, cmd.div_step, steps_q != '0)
	`CRM_ASSERT_NXT(a_out_loaded, cmd.out_ld, out_valid_q)
	`CRM_ASSERT_IMP(a_march_dir, cmd.march, (dx_q != '0) || (dy_q != '0))

endmodule

// File: design/column_ray_marcher.sv
// A load transaction (tuser = 0) writes one wall map row. A cast
// transaction (tuser = 1) takes an accept state, direction lookup in ST_SIN, ST_COS and ST_SETX,
// the march at one unit step per cycle (up to MAX_STEPS steps), the bit-serial
// line height divide when a wall is hit, and the write of the result register,
// which stalls while the output register is still full. One item is in work at
// a time; a finished result waits in the output register.
// Top level; depends on crm_pkg, crm_ctrl and crm_dpath.
module column_ray_marcher #(
	parameter int MAP_CELLS   = 10,
	parameter int TILE_SHIFT  = 6,
	parameter int COLUMNS     = 640,
	parameter int SCREEN_ROWS = 480,
	parameter int MAX_STEPS   = 1024,
	parameter int FRAC_BITS   = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// map_row[3:0] row_walls[13:4] column[23:14] pos_x[47:24] pos_y[71:48] view_angle[83:72]
	input  logic [87:0] s_tdata,
	// func[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// column_out[9:0] step_count[20:10] line_top[28:21] line_bottom[37:29]
	output logic [39:0] m_tdata,
	// hit[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	crm_pkg::cmd_t cmd;
	crm_pkg::sts_t sts;

	crm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.func    (s_tuser[0]),
		.sts     (sts),
		.s_ready (s_tready),
		.cmd     (cmd)
	);

	crm_dpath #(
		.MAP_CELLS   (MAP_CELLS),
		.TILE_SHIFT  (TILE_SHIFT),
		.COLUMNS     (COLUMNS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.MAX_STEPS   (MAX_STEPS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (s_tuser[0]),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_hit   (m_tuser[0])
	);

endmodule
